// File: rtl/ooksb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ooksb_pkg: shared definitions of the OOK sync-byte demodulator
// Field widths, register indexes, mode codes and the per-packet state record.
// ----------------------------------------------------------------------------
package ooksb_pkg;

    localparam int AMP_W       = 16;
    localparam int TIME_W      = 32;
    localparam int BIT_TIME_W  = 10;
    localparam int PERIOD_W    = 20;   // bit time in microseconds
    localparam int MAX_BYTES_W = 9;
    localparam int BYTE_W      = 8;
    localparam int BITS_W      = 6;
    localparam int LOW_W       = 5;
    localparam int COUNT_W     = 16;

    localparam int IN_DATA_W   = AMP_W + TIME_W;                         // 48
    localparam int OUT_DATA_W  = 3 * BYTE_W + TIME_W + 2 * COUNT_W;      // 88

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_ON_THRESHOLD  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFF_THRESHOLD = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BIT_TIME_MS   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_BYTE     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_BYTES     = 3'd4;

    localparam int US_PER_MS = 1000;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_SYNC = 2'd1;
    localparam logic [1:0] MODE_RECV = 2'd2;
    localparam logic [1:0] MODE_DONE = 2'd3;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Everything a soft restart clears; all-zero is the restart value.
    typedef struct packed {
        logic [1:0]        mode;
        logic [BYTE_W-1:0] window;
        logic [BITS_W-1:0] bits;
        logic [BYTE_W-1:0] bytes;
        logic [LOW_W-1:0]  low;
        logic [TIME_W-1:0] bit_start;
        logic [TIME_W-1:0] detect;
        logic [TIME_W-1:0] complete;
    } demod_state_t;

endpackage

// File: rtl/ook_sync_byte_demodulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ook_sync_byte_demodulator: on-off-keyed receiver with sync-byte framing
// Slices amplitude samples into bits, hunts for a sync byte and emits the
// bytes of each packet followed by a packet-end record.
// ----------------------------------------------------------------------------
// Usage:
// Each input word on the s_axis channel is one amplitude sample with its
// microsecond timestamp. The block captures it into an input register and,
// once the output register is empty or draining, runs the whole per-sample
// update (threshold compares, bit-period check, shift window, byte and
// low-sample counters); when the sample produces a result, it loads it into
// the m_axis output register. One sample per cycle is sustained while
// m_axis_tready stays high; the limit is the single update stage, which holds
// the demodulator state and must see samples strictly in order.
// The configuration port writes one register per cycle with cfg_wr_en; the
// user must use it only while the block is idle, as the block does not
// enforce this. After reset the thresholds and the sync byte are zero, the
// bit time is 10 ms, the packet limit is 64 bytes, and the counters are
// cleared. When the receiver holds m_axis_tready low, the pending result
// stays in the output register, the sample already captured waits in the
// input register, and s_axis_tready drops until the output frees.
// ----------------------------------------------------------------------------
module ook_sync_byte_demodulator (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Fields from bit 0: amplitude[15:0], now_us[47:16].
    input  logic [ooksb_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // Fields from bit 0: data_byte[7:0], byte_index[15:8], packet_length[23:16],
    // pkt_span_us[55:24], sync_error_count[71:56], packet_count[87:72].
    output logic [ooksb_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // Fields from bit 0: kind[0].
    output logic                                m_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic                                cfg_wr_en,
    input  logic [ooksb_pkg::CFG_INDEX_W-1:0]   cfg_wr_index,
    input  logic [ooksb_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);
    import ooksb_pkg::*;

    // Configuration registers. The bit time is kept already scaled to
    // microseconds so the per-sample path only subtracts and compares.
    logic [AMP_W-1:0]       on_thr_reg;
    logic [AMP_W-1:0]       off_thr_reg;
    logic [PERIOD_W-1:0]    period_reg;
    logic [BYTE_W-1:0]      sync_reg;
    logic [MAX_BYTES_W-1:0] max_bytes_reg;

    // Input register.
    logic                   in_valid_reg;
    logic                   in_valid_next;
    logic [AMP_W-1:0]       amp_reg;
    logic [TIME_W-1:0]      now_reg;

    // Demodulator state.
    demod_state_t           st_reg;
    demod_state_t           st_next;
    logic [COUNT_W-1:0]     err_reg;
    logic [COUNT_W-1:0]     err_next;
    logic [COUNT_W-1:0]     pkt_reg;
    logic [COUNT_W-1:0]     pkt_next;

    // Output register.
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   out_kind_reg;
    logic [OUT_DATA_W-1:0]  out_data_reg;

    logic                   proceed;
    logic                   emit;
    logic                   res_kind;
    logic [OUT_DATA_W-1:0]  res_data;

    // The update stage advances when it holds a sample and the output
    // register is empty or being drained in this cycle.
    assign proceed       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || proceed;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_axis_tvalid && s_axis_tready) begin
            in_valid_next = 1'b1;
        end else if (proceed) begin
            in_valid_next = 1'b0;
        end
    end

    // Per-sample update, written in the order the decisions are made: the
    // low-sample check always runs after the bit handling of the same sample.
    always_comb begin
        logic                   bit_one;
        logic                   is_low;
        logic                   bit_due;
        logic [TIME_W-1:0]      elapsed;
        logic [MAX_BYTES_W-1:0] limit;
        logic [BYTE_W-1:0]      rx_byte;
        logic                   at_limit;

        st_next  = st_reg;
        err_next = err_reg;
        pkt_next = pkt_reg;
        emit     = 1'b0;
        res_kind = KIND_DATA;
        res_data = '0;

        bit_one  = amp_reg > on_thr_reg;
        is_low   = amp_reg < off_thr_reg;
        elapsed  = now_reg - st_reg.bit_start;
        bit_due  = elapsed >= {{(TIME_W-PERIOD_W){1'b0}}, period_reg};
        limit    = (max_bytes_reg > MAX_BYTES_W'(256)) ? MAX_BYTES_W'(256) : max_bytes_reg;
        rx_byte  = '0;
        at_limit = 1'b0;

        case (st_reg.mode)
            MODE_IDLE: begin
                if (bit_one) begin
                    st_next.detect    = now_reg;
                    st_next.mode      = MODE_SYNC;
                    st_next.window    = '0;
                    st_next.bits      = '0;
                    st_next.bit_start = now_reg;
                    st_next.low       = '0;
                end
            end

            MODE_SYNC: begin
                if (bit_due) begin
                    st_next.window    = {st_reg.window[BYTE_W-2:0], bit_one};
                    st_next.bits      = st_reg.bits + BITS_W'(1);
                    st_next.bit_start = now_reg;
                    if (st_next.bits >= BITS_W'(8)) begin
                        if (st_next.window == sync_reg) begin
                            st_next.mode   = MODE_RECV;
                            st_next.bytes  = '0;
                            st_next.bits   = '0;
                            st_next.window = '0;
                        end else if (st_next.bits > BITS_W'(32)) begin
                            if (err_reg != {COUNT_W{1'b1}}) begin
                                err_next = err_reg + COUNT_W'(1);
                            end
                            st_next = '0;
                        end
                    end
                end
                if (is_low) begin
                    if (st_next.low != {LOW_W{1'b1}}) begin
                        st_next.low = st_next.low + LOW_W'(1);
                    end
                end else begin
                    st_next.low = '0;
                end
                if (st_next.low > LOW_W'(10)) begin
                    st_next = '0;
                end
            end

            MODE_RECV: begin
                if (bit_due) begin
                    st_next.window    = {st_reg.window[BYTE_W-2:0], bit_one};
                    st_next.bits      = st_reg.bits + BITS_W'(1);
                    st_next.bit_start = now_reg;
                    if (st_next.bits == BITS_W'(8)) begin
                        rx_byte  = st_next.window;
                        emit     = 1'b1;
                        res_kind = KIND_DATA;
                        res_data = {pkt_reg, err_reg, {TIME_W{1'b0}}, {BYTE_W{1'b0}},
                                    st_reg.bytes, rx_byte};
                        st_next.bytes  = st_reg.bytes + BYTE_W'(1);
                        st_next.bits   = '0;
                        st_next.window = '0;
                        at_limit = ({1'b0, st_next.bytes} >= limit - MAX_BYTES_W'(1));
                        if (rx_byte == '0 || limit < MAX_BYTES_W'(2) || at_limit) begin
                            st_next.complete = now_reg;
                            if (st_next.bytes != '0) begin
                                st_next.mode = MODE_DONE;
                            end else begin
                                st_next = '0;
                            end
                        end
                    end
                end
                if (is_low) begin
                    if (st_next.low != {LOW_W{1'b1}}) begin
                        st_next.low = st_next.low + LOW_W'(1);
                    end
                end else begin
                    st_next.low = '0;
                end
                if (st_next.low > LOW_W'(15)) begin
                    st_next.complete = now_reg;
                    if (st_next.bytes != '0) begin
                        st_next.mode = MODE_DONE;
                    end else begin
                        st_next = '0;
                    end
                end
            end

            default: begin
                // Packet finished on the previous sample: report it and restart.
                if (pkt_reg != {COUNT_W{1'b1}}) begin
                    pkt_next = pkt_reg + COUNT_W'(1);
                end
                emit     = 1'b1;
                res_kind = KIND_END;
                res_data = {pkt_next, err_reg, st_reg.complete - st_reg.detect,
                            st_reg.bytes, {BYTE_W{1'b0}}, {BYTE_W{1'b0}}};
                st_next  = '0;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (proceed && emit) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            on_thr_reg    <= '0;
            off_thr_reg   <= '0;
            period_reg    <= PERIOD_W'(10 * US_PER_MS);
            sync_reg      <= '0;
            max_bytes_reg <= MAX_BYTES_W'(64);
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_ON_THRESHOLD:  on_thr_reg  <= cfg_wr_data[AMP_W-1:0];
                CFG_OFF_THRESHOLD: off_thr_reg <= cfg_wr_data[AMP_W-1:0];
                CFG_BIT_TIME_MS: begin
                    period_reg <= PERIOD_W'(PERIOD_W'(cfg_wr_data[BIT_TIME_W-1:0])
                                  * PERIOD_W'(US_PER_MS));
                end
                CFG_SYNC_BYTE:     sync_reg      <= cfg_wr_data[BYTE_W-1:0];
                CFG_MAX_BYTES:     max_bytes_reg <= cfg_wr_data[MAX_BYTES_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
            err_reg       <= '0;
            pkt_reg       <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (proceed) begin
                st_reg  <= st_next;
                err_reg <= err_next;
                pkt_reg <= pkt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            amp_reg <= s_axis_tdata[AMP_W-1:0];
            now_reg <= s_axis_tdata[AMP_W +: TIME_W];
        end
        if (proceed && emit) begin
            out_kind_reg <= res_kind;
            out_data_reg <= res_data;
        end
    end

`ifndef SYNTHESIS
    // A packet-end record always reports at least one byte.
    a_end_has_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser == KIND_END) |-> (m_axis_tdata[23:16] != '0))
        else $error("packet end record with zero length");

    // A data word carries no packet length and no duration.
    a_data_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser == KIND_DATA) |->
        (m_axis_tdata[23:16] == '0 && m_axis_tdata[55:24] == '0))
        else $error("data word carries packet-end fields");

    // Done is only reached with a non-empty packet.
    a_done_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg.mode == MODE_DONE) |-> (st_reg.bytes != '0))
        else $error("done state with empty packet");

    // The bit counter restarts at every eighth bit while receiving.
    a_recv_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg.mode == MODE_RECV) |-> (st_reg.bits < BITS_W'(8)))
        else $error("receive bit counter passed a byte boundary");

    // Signal loss in sync restarts as soon as the low run exceeds ten samples.
    a_sync_low: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg.mode == MODE_SYNC) |-> (st_reg.low <= LOW_W'(10)))
        else $error("sync low run not handled");
`endif

endmodule

// File: test/ook_sync_byte_demodulator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ook_sync_byte_demodulator_test: self-checking bench for the OOK demodulator
// Streams amplitude samples shaped into carrier bursts, sync bytes and packets,
// predicts every data byte and packet-end word, and checks each output word
// field by field under random stalls on both sides.
// ----------------------------------------------------------------------------
module ook_sync_byte_demodulator_test;

    import ooksb_pkg::*;

    localparam int SETTLE_CYCLES   = 6;     // a sample may still be in flight
    localparam int HOLD_OFF_CYCLES = 300;   // long receiver stall
    localparam int STALL_LIMIT     = 3000;  // cycles without any handshake

    // One expected output word, split into its fields.
    typedef struct {
        bit        kind;
        bit [7:0]  data_byte;
        bit [7:0]  byte_index;
        bit [7:0]  packet_length;
        bit [31:0] span_us;
        bit [15:0] sync_errors;
        bit [15:0] packets;
    } demod_result_t;

    // The ways a generated packet is brought to its end.
    typedef enum {END_ZERO_BYTE, END_LOW_RUN, END_AT_LIMIT} packet_end_t;

    // Demodulator predictor and store of expected words.
    class demod_scoreboard;
        bit [15:0] on_thr, off_thr;
        bit [9:0]  bit_ms;
        bit [7:0]  sync_pat;
        bit [8:0]  max_bytes;

        bit [1:0]  mode;
        bit [7:0]  window;
        bit [5:0]  bits;
        bit [7:0]  nbytes;
        bit [4:0]  low_run;
        bit [31:0] bit_start, detect_at, complete_at;
        bit [15:0] err_total, pkt_total;

        demod_result_t pending[$];
        int fail_count;

        function new();
            on_thr    = '0;
            off_thr   = '0;
            bit_ms    = 10'd10;
            sync_pat  = '0;
            max_bytes = 9'd64;
            err_total = '0;
            pkt_total = '0;
            fail_count = 0;
            soft_restart();
        endfunction

        function void soft_restart();
            mode        = MODE_IDLE;
            window      = '0;
            bits        = '0;
            nbytes      = '0;
            low_run     = '0;
            bit_start   = '0;
            detect_at   = '0;
            complete_at = '0;
        endfunction

        function void write_reg(bit [CFG_INDEX_W-1:0] idx, bit [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_ON_THRESHOLD:  on_thr    = val;
                CFG_OFF_THRESHOLD: off_thr   = val;
                CFG_BIT_TIME_MS:   bit_ms    = val[9:0];
                CFG_SYNC_BYTE:     sync_pat  = val[7:0];
                CFG_MAX_BYTES:     max_bytes = val[8:0];
                default: ;
            endcase
        endfunction

        function void slice(bit [15:0] amp, bit [31:0] now);
            window    = {window[6:0], amp > on_thr};
            bits      = 6'(bits + 6'd1);
            bit_start = now;
        endfunction

        function void track_low(bit [15:0] amp);
            if (amp < off_thr) begin
                if (low_run != 5'd31) low_run = 5'(low_run + 5'd1);
            end else begin
                low_run = '0;
            end
        endfunction

        function void end_packet(bit [31:0] now);
            complete_at = now;
            if (nbytes != 0) mode = MODE_DONE;
            else soft_restart();
        endfunction

        function void push_word(bit kind, bit [7:0] data_v, bit [7:0] idx_v,
                                bit [7:0] len_v, bit [31:0] dur_v);
            demod_result_t r;
            r.kind          = kind;
            r.data_byte     = data_v;
            r.byte_index    = idx_v;
            r.packet_length = len_v;
            r.span_us       = dur_v;
            r.sync_errors   = err_total;
            r.packets       = pkt_total;
            pending.push_back(r);
        endfunction

        // Advances the demodulator by one accepted sample.
        function void note_sample(bit [15:0] amp, bit [31:0] now);
            bit [31:0] period;
            bit        due;
            bit [7:0]  got_byte;
            int        limit;
            period = 32'(bit_ms) * 32'(US_PER_MS);
            due    = (now - bit_start) >= period;
            case (mode)
                MODE_IDLE: begin
                    if (amp > on_thr) begin
                        detect_at = now;
                        mode      = MODE_SYNC;
                        window    = '0;
                        bits      = '0;
                        bit_start = now;
                        low_run   = '0;
                    end
                end
                MODE_SYNC: begin
                    if (due) begin
                        slice(amp, now);
                        if (bits >= 6'd8) begin
                            if (window == sync_pat) begin
                                mode   = MODE_RECV;
                                nbytes = '0;
                                bits   = '0;
                                window = '0;
                            end else if (bits > 6'd32) begin
                                if (err_total != 16'hFFFF) err_total = 16'(err_total + 16'd1);
                                soft_restart();
                            end
                        end
                    end
                    track_low(amp);
                    if (low_run > 5'd10) soft_restart();
                end
                MODE_RECV: begin
                    if (due) begin
                        slice(amp, now);
                        if (bits == 6'd8) begin
                            got_byte = window;
                            limit    = (max_bytes > 9'd256) ? 256 : int'(max_bytes);
                            push_word(KIND_DATA, got_byte, nbytes, 8'd0, 32'd0);
                            nbytes = 8'(nbytes + 8'd1);
                            bits   = '0;
                            window = '0;
                            if (got_byte == 8'd0 || limit < 2 || int'(nbytes) >= limit - 1)
                                end_packet(now);
                        end
                    end
                    track_low(amp);
                    if (low_run > 5'd15) end_packet(now);
                end
                default: begin
                    // The sample after a finished packet only releases the end word.
                    if (pkt_total != 16'hFFFF) pkt_total = 16'(pkt_total + 16'd1);
                    push_word(KIND_END, 8'd0, 8'd0, nbytes, complete_at - detect_at);
                    soft_restart();
                end
            endcase
        endfunction

        function void compare_field(string name, bit [31:0] want, bit [31:0] got);
            if (want != got) begin
                $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
                fail_count++;
            end
        endfunction

        function void check_word(bit [OUT_DATA_W-1:0] data, bit kind);
            demod_result_t want;
            if (pending.size() == 0) begin
                $display("%0t ns: word with none expected, actual kind %0d data %0h",
                         $time, kind, data);
                fail_count++;
                return;
            end
            want = pending.pop_front();
            compare_field("kind", 32'(want.kind), 32'(kind));
            compare_field("data_byte", 32'(want.data_byte), 32'(data[7:0]));
            compare_field("byte_index", 32'(want.byte_index), 32'(data[15:8]));
            compare_field("packet_length", 32'(want.packet_length), 32'(data[23:16]));
            compare_field("pkt_span_us", want.span_us, data[55:24]);
            compare_field("sync_error_count", 32'(want.sync_errors), 32'(data[71:56]));
            compare_field("packet_count", 32'(want.packets), 32'(data[87:72]));
        endfunction
    endclass

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    // Fields from bit 0: amplitude[15:0], now_us[47:16].
    logic [IN_DATA_W-1:0]     s_axis_tdata = '0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    // Fields from bit 0: data_byte[7:0], byte_index[15:8], packet_length[23:16],
    // pkt_span_us[55:24], sync_error_count[71:56], packet_count[87:72].
    logic [OUT_DATA_W-1:0]    m_axis_tdata;
    // Fields from bit 0: kind[0].
    logic                     m_axis_tuser;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0]   cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_wr_data = '0;

    demod_scoreboard sb = new();

    bit        no_idle = 1'b0;        // both sides run without gaps
    bit        stall_request = 1'b0;  // the next phase starts with a long stall
    bit        hold_receiver = 1'b0;  // asks the receiver for one long stall
    int        items_sent = 0;
    int        stall_cycles = 0;
    bit [31:0] gen_now = '0;          // timestamp of the last bit boundary sent

    ook_sync_byte_demodulator u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Every accepted output word is checked against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            sb.check_word(m_axis_tdata, m_axis_tuser);
    end

    // The watchdog ends a run in which nothing moves on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // The receiver stalls at random. On request it holds off for a long stretch
    // while the sender keeps offering samples, so the block has to back up.
    initial begin
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (hold_receiver) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_receiver = 1'b0;
            end
            m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 36);
        end
    end

    // Offers one sample, with random idle cycles before it, and waits until the
    // block takes it. The predictor is advanced at the accepting edge.
    task automatic put(input bit [15:0] amp, input bit [31:0] now);
        while (!no_idle && $urandom_range(0, 99) < 36) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tdata  <= {now, amp};
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_sample(amp, now);
        items_sent++;
    endtask

    // Waits until every expected word is out and the pipeline has emptied.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input bit [CFG_INDEX_W-1:0] idx, input bit [CFG_DATA_W-1:0] val);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
    endtask

    task automatic configure(input bit [15:0] on_v, input bit [15:0] off_v,
                             input bit [9:0] ms_v, input bit [7:0] sync_v,
                             input bit [8:0] max_v);
        drain();
        write_reg(CFG_ON_THRESHOLD, on_v);
        write_reg(CFG_OFF_THRESHOLD, off_v);
        write_reg(CFG_BIT_TIME_MS, 16'(ms_v));
        write_reg(CFG_SYNC_BYTE, 16'(sync_v));
        write_reg(CFG_MAX_BYTES, 16'(max_v));
        cfg_wr_en <= 1'b0;
    endtask

    function automatic int unsigned bit_period();
        return 32'(sb.bit_ms) * 32'(US_PER_MS);
    endfunction

    // Amplitude above the on threshold: carrier present, bit one.
    function automatic bit [15:0] one_amp();
        if (sb.on_thr == 16'hFFFF) return 16'hFFFF;
        return 16'($urandom_range(32'(sb.on_thr) + 1, 65535));
    endfunction

    // Amplitude read as bit zero, kept out of the low range where possible.
    function automatic bit [15:0] zero_amp();
        if (sb.off_thr <= sb.on_thr)
            return 16'($urandom_range(32'(sb.off_thr), 32'(sb.on_thr)));
        return 16'($urandom_range(0, 32'(sb.on_thr)));
    endfunction

    // Amplitude below the off threshold, counted as signal loss.
    function automatic bit [15:0] low_amp();
        if (sb.off_thr == 16'd0) return zero_amp();
        return 16'($urandom_range(0, 32'(sb.off_thr) - 1));
    endfunction

    function automatic bit [15:0] bit_level(input bit b);
        return b ? one_amp() : zero_amp();
    endfunction

    // One bit: sometimes a few samples inside the bit period that must not be
    // sliced, then the sample that lands on (or a little past) the boundary.
    task automatic send_bit(input bit b);
        int unsigned period;
        int unsigned late;
        period = bit_period();
        if (period > 0 && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2))
                put(bit_level(b), gen_now + 32'($urandom_range(0, period - 1)));
        late = ($urandom_range(0, 3) == 0) ? $urandom_range(0, period / 4) : 0;
        gen_now = gen_now + 32'(period) + 32'(late);
        put(bit_level(b), gen_now);
    endtask

    task automatic send_byte(input bit [7:0] v);
        for (int i = 7; i >= 0; i--) send_bit(v[i]);
    endtask

    // A run of low samples inside the current bit period. With last_due set the
    // final one falls on the bit boundary, so it can also complete a byte.
    task automatic send_low_run(input int n, input bit last_due);
        int unsigned period;
        period = bit_period();
        for (int i = 0; i < n; i++) begin
            if (last_due && i == n - 1) begin
                gen_now = gen_now + 32'(period);
                put(low_amp(), gen_now);
            end else begin
                put(low_amp(), gen_now + 32'(period == 0 ? 0 : $urandom_range(0, period - 1)));
            end
        end
    endtask

    task automatic detect_carrier();
        gen_now = gen_now + 32'($urandom_range(1, 20000));
        put(one_amp(), gen_now);
    endtask

    // A well-formed burst: carrier, a short preamble, the sync byte, data bytes,
    // the chosen ending, then the sample that releases the packet-end word.
    task automatic good_packet(input int n_bytes, input packet_end_t ending);
        detect_carrier();
        repeat ($urandom_range(0, 3)) send_bit(1'($urandom_range(0, 1)));
        send_byte(sb.sync_pat);
        repeat (n_bytes) send_byte(8'($urandom_range(1, 255)));
        case (ending)
            END_ZERO_BYTE: send_byte(8'd0);
            END_LOW_RUN: begin
                if ($urandom_range(0, 1) == 1) begin
                    // Seven bits first, so the sixteenth low sample closes a byte too.
                    repeat (7) send_bit(1'($urandom_range(0, 1)));
                    send_low_run(16, 1'b1);
                end else begin
                    send_low_run($urandom_range(16, 19), 1'b0);
                end
            end
            default: ;
        endcase
        gen_now = gen_now + 32'($urandom_range(1, 1000));
        put(16'($urandom_range(0, 65535)), gen_now);
        repeat ($urandom_range(0, 3)) begin
            gen_now = gen_now + 32'($urandom_range(1, 500));
            put(zero_amp(), gen_now);
        end
    endtask

    // Mostly clean packets; the rest are sync timeouts, lost signals and noise.
    task automatic random_sequence();
        int  pick;
        int  limit;
        int  lim_bytes;
        bit  flat;
        pick  = $urandom_range(0, 99);
        limit = (sb.max_bytes > 9'd256) ? 256 : int'(sb.max_bytes);
        lim_bytes = (limit < 2) ? 1 : limit - 1;
        if (pick < 60) begin
            pick = $urandom_range(0, 2);
            if (pick == 2 && lim_bytes <= 12)
                good_packet(lim_bytes, END_AT_LIMIT);
            else if (pick == 1 && sb.off_thr != 16'd0)
                good_packet($urandom_range(0, 3), END_LOW_RUN);
            else
                good_packet($urandom_range(0, (lim_bytes > 3) ? 3 : lim_bytes - 1),
                            END_ZERO_BYTE);
        end else if (pick < 75) begin
            // A steady level that can never match the sync byte runs into the timeout.
            flat = (sb.sync_pat == 8'hFF) ? 1'b0 : 1'b1;
            detect_carrier();
            repeat ($urandom_range(33, 38)) send_bit(flat);
        end else if (pick < 85) begin
            detect_carrier();
            repeat ($urandom_range(0, 6)) send_bit(1'($urandom_range(0, 1)));
            send_low_run($urandom_range(11, 13), 1'b0);
        end else begin
            repeat ($urandom_range(1, 5)) put(16'($urandom_range(0, 65535)), $urandom());
        end
    endtask

    // A new setting, the time base moved close to the 32-bit wrap, then random
    // sequences until the phase has sent its share of samples. A pending stall
    // request starts the long receiver hold once the new setting is in place.
    task automatic run_phase(input bit [15:0] on_v, input bit [15:0] off_v,
                             input bit [9:0] ms_v, input bit [7:0] sync_v,
                             input bit [8:0] max_v, input int budget);
        int first_item;
        configure(on_v, off_v, ms_v, sync_v, max_v);
        if (stall_request) begin
            hold_receiver = 1'b1;
            stall_request = 1'b0;
        end
        gen_now = 32'hFFFF_FFFF - 32'($urandom_range(0, 3 * bit_period() + 20000));
        first_item = items_sent;
        while (items_sent - first_item < budget) random_sequence();
    endtask

    initial begin
        bit [15:0] on_r;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed packet at the reset settings: zero thresholds, zero sync
        // byte, 10 ms bits. The carrier is detected at the last timestamp before
        // the wrap, so the packet duration is measured across it.
        put(16'h0000, 32'h0000_0000);
        gen_now = 32'hFFFF_FFFF;
        put(16'hFFFF, gen_now);
        send_byte(8'h00);
        send_byte(8'h81);
        send_byte(8'h00);
        gen_now = gen_now + 32'd1;
        put(16'hFFFF, gen_now);

        // The receiver holds off once, early, while packets keep arriving.
        stall_request = 1'b1;
        run_phase(16'h8000, 16'h1000, 10'd1, 8'hA5, 9'd64, 180);

        // Zero bit time slices on every sample; a limit of two bytes ends packets
        // after one. This phase also runs with no idle cycles on either side.
        no_idle = 1'b1;
        run_phase(16'h0000, 16'h0000, 10'd0, 8'h00, 9'd2, 130);
        no_idle = 1'b0;

        // Highest thresholds, longest legal bit time, a limit of one byte.
        run_phase(16'hFFFE, 16'hFFFF, 10'd1000, 8'hFF, 9'd1, 100);

        // Bit time beyond the legal range and a limit of zero.
        on_r = 16'($urandom_range(16'h0100, 16'hF000));
        run_phase(on_r, 16'($urandom_range(0, 32'(on_r))), 10'd1023,
                  8'($urandom_range(0, 255)), 9'd0, 130);

        // An on threshold that nothing exceeds: the block never leaves idle.
        run_phase(16'hFFFF, 16'h0000, 10'd5, 8'h3C, 9'd256, 30);

        // A limit above 256 acts as 256, so packets here end only on a zero byte
        // or a low run.
        run_phase(16'h4000, 16'h0400, 10'd0, 8'h5A, 9'd511, 90);

        repeat (4) begin
            on_r = 16'($urandom_range(16'h0100, 16'hF000));
            run_phase(on_r, 16'($urandom_range(0, 32'(on_r))),
                      10'($urandom_range(1, 1000)), 8'($urandom_range(0, 255)),
                      9'($urandom_range(2, 12)), 150);
        end

        drain();
        if (sb.fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
rtl/ooksb_pkg.sv
rtl/ook_sync_byte_demodulator.sv
test/ook_sync_byte_demodulator_test.sv
